// File: hdl/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ldc_pkg.sv
// Types, constants and helpers of the lateral deviation classifier.
`default_nettype none

package ldc_pkg;

    localparam int unsigned SAMPLE_BITS = 12;
    localparam int unsigned CNT_BITS    = 16;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned IDX_W       = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CNT_BITS-1:0]    count_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LINE_CENTER     = 3'd0,
        REG_LEFT_MIN_FRONT  = 3'd1,
        REG_RIGHT_MAX_FRONT = 3'd2,
        REG_LEFT_MIN_BACK   = 3'd3,
        REG_RIGHT_MAX_BACK  = 3'd4,
        REG_LEFT_EXTREME    = 3'd5,
        REG_RIGHT_EXTREME   = 3'd6,
        REG_EXT_COUNT_LIMIT = 3'd7
    } ldc_reg_idx_t;

    localparam sample_t RST_LINE_CENTER     = 12'd2048;
    localparam sample_t RST_LEFT_MIN_FRONT  = 12'd1948;
    localparam sample_t RST_RIGHT_MAX_FRONT = 12'd2148;
    localparam sample_t RST_LEFT_MIN_BACK   = 12'd1948;
    localparam sample_t RST_RIGHT_MAX_BACK  = 12'd2148;
    localparam sample_t RST_LEFT_EXTREME    = 12'd500;
    localparam sample_t RST_RIGHT_EXTREME   = 12'd3600;
    localparam count_t  RST_EXT_COUNT_LIMIT = 16'd50;

    // Attitude cases
    localparam logic [2:0] ATT_LEFT_TOWARD  = 3'd0;
    localparam logic [2:0] ATT_RIGHT_TOWARD = 3'd1;
    localparam logic [2:0] ATT_LEFT_AWAY    = 3'd2;
    localparam logic [2:0] ATT_RIGHT_AWAY   = 3'd3;
    localparam logic [2:0] ATT_INSIDE       = 3'd4;

    localparam count_t CNT_MAX = '1;

    typedef struct packed {
        sample_t line_center;
        sample_t left_min_front;
        sample_t right_max_front;
        sample_t left_min_back;
        sample_t right_max_back;
        sample_t left_extreme;
        sample_t right_extreme;
        count_t  extreme_count_limit;
    } ldc_cfg_t;

    typedef struct packed {
        logic    backward;
        logic    forward;
        sample_t back_distance;
        sample_t front_distance;
    } ldc_item_t;

    typedef struct packed {
        logic       aligned_ok;
        logic       left_error;
        logic       right_error;
        logic       center_right;
        sample_t    center_offset;
        logic       rear_larger;
        sample_t    sensor_difference;
        logic [2:0] attitude_case;
    } ldc_result_t;

    // Saturating increment
    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == CNT_MAX) ? c : c + count_t'(1);
    endfunction

    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ldc_cfg_regs.sv
// Configuration register bank of the lateral deviation classifier.
`default_nettype none

module ldc_cfg_regs
    import ldc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    output ldc_cfg_t                cfg
);

    ldc_cfg_t cfg_reg;
    ldc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (ldc_reg_idx_t'(cfg_index))
                REG_LINE_CENTER:     cfg_next.line_center     = cfg_wdata[SAMPLE_BITS-1:0];
                REG_LEFT_MIN_FRONT:  cfg_next.left_min_front  = cfg_wdata[SAMPLE_BITS-1:0];
                REG_RIGHT_MAX_FRONT: cfg_next.right_max_front = cfg_wdata[SAMPLE_BITS-1:0];
                REG_LEFT_MIN_BACK:   cfg_next.left_min_back   = cfg_wdata[SAMPLE_BITS-1:0];
                REG_RIGHT_MAX_BACK:  cfg_next.right_max_back  = cfg_wdata[SAMPLE_BITS-1:0];
                REG_LEFT_EXTREME:    cfg_next.left_extreme    = cfg_wdata[SAMPLE_BITS-1:0];
                REG_RIGHT_EXTREME:   cfg_next.right_extreme   = cfg_wdata[SAMPLE_BITS-1:0];
                REG_EXT_COUNT_LIMIT: cfg_next.extreme_count_limit = cfg_wdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_center         <= RST_LINE_CENTER;
            cfg_reg.left_min_front      <= RST_LEFT_MIN_FRONT;
            cfg_reg.right_max_front     <= RST_RIGHT_MAX_FRONT;
            cfg_reg.left_min_back       <= RST_LEFT_MIN_BACK;
            cfg_reg.right_max_back      <= RST_RIGHT_MAX_BACK;
            cfg_reg.left_extreme        <= RST_LEFT_EXTREME;
            cfg_reg.right_extreme       <= RST_RIGHT_EXTREME;
            cfg_reg.extreme_count_limit <= RST_EXT_COUNT_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/ldc_core.sv
// Classification logic and tracking state of the lateral deviation classifier.
`default_nettype none

module ldc_core
    import ldc_pkg::*;
#(
    parameter int unsigned ZERO_READING_LIMIT = 20,
    parameter int unsigned HYST_MARGIN        = 10
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ldc_cfg_t  cfg,
    input  wire ldc_item_t item,
    input  wire logic      fire,
    output ldc_result_t    result
);

    localparam int unsigned BW = SAMPLE_BITS + 1;

    logic    front_left_reg, front_right_reg, back_left_reg, back_right_reg;
    logic    front_left_next, front_right_next, back_left_next, back_right_next;
    sample_t offset_reg, offset_next;
    logic    center_side_reg, center_side_next;
    count_t  extreme_cnt_reg, extreme_cnt_next;
    count_t  zero_cnt_reg, zero_cnt_next;
    count_t  settle_cnt_reg, settle_cnt_next;
    logic    aligned_reg, aligned_next;
    logic    right_err_reg, right_err_next;
    logic    left_err_reg, left_err_next;

    sample_t f, b, s, lo_thr, hi_thr;
    logic    fwd, bwd, upd, rear_big, s_left, s_right;
    logic    over_right, over_left, in_band;
    logic [BW-1:0] f_w, b_w, hi_w, lo_w;
    count_t  ext_inc, zero_inc, settle_inc;
    logic [2:0] att;

    assign f   = item.front_distance;
    assign b   = item.back_distance;
    assign fwd = item.forward;
    assign bwd = item.backward;
    assign upd = fwd | bwd;

    assign rear_big = b > f;

    // Active sensor and its zone thresholds
    assign s      = fwd ? f : b;
    assign lo_thr = fwd ? cfg.left_min_front  : cfg.left_min_back;
    assign hi_thr = fwd ? cfg.right_max_front : cfg.right_max_back;
    assign s_left  = s < lo_thr;
    assign s_right = !s_left && (s > hi_thr);

    // Inner hysteresis band, widened by one bit so the margin never wraps
    assign f_w  = {1'b0, f};
    assign b_w  = {1'b0, b};
    assign hi_w = {1'b0, cfg.right_extreme};
    assign lo_w = {1'b0, cfg.left_extreme} + BW'(HYST_MARGIN);
    assign over_right = (f > cfg.right_extreme) || (b > cfg.right_extreme);
    assign over_left  = (f < cfg.left_extreme)  || (b < cfg.left_extreme);
    assign in_band = (f_w + BW'(HYST_MARGIN) < hi_w) && (f_w > lo_w) &&
                     (b_w + BW'(HYST_MARGIN) < hi_w) && (b_w > lo_w);

    assign ext_inc    = sat_inc(extreme_cnt_reg);
    assign zero_inc   = sat_inc(zero_cnt_reg);
    assign settle_inc = sat_inc(settle_cnt_reg);

    always_comb begin
        front_left_next  = front_left_reg;
        front_right_next = front_right_reg;
        back_left_next   = back_left_reg;
        back_right_next  = back_right_reg;
        offset_next      = offset_reg;
        center_side_next = center_side_reg;
        if (fwd) begin
            front_left_next  = s_left;
            front_right_next = s_right;
        end else if (bwd) begin
            back_left_next  = s_left;
            back_right_next = s_right;
        end
        if (upd) begin
            offset_next = abs_diff(s, cfg.line_center);
            if (!s_left && !s_right) begin
                center_side_next = s > cfg.line_center;
            end
        end
    end

    always_comb begin
        extreme_cnt_next = extreme_cnt_reg;
        zero_cnt_next    = zero_cnt_reg;
        settle_cnt_next  = settle_cnt_reg;
        aligned_next     = aligned_reg;
        right_err_next   = right_err_reg;
        left_err_next    = left_err_reg;
        if (over_right) begin
            if ((f == '0 || b == '0) && !aligned_reg) begin
                extreme_cnt_next = '0;
                zero_cnt_next    = zero_inc;
                if (zero_inc > count_t'(ZERO_READING_LIMIT)) begin
                    zero_cnt_next  = '0;
                    right_err_next = 1'b1;
                    left_err_next  = 1'b0;
                end
            end else begin
                zero_cnt_next    = '0;
                extreme_cnt_next = ext_inc;
                if (ext_inc > cfg.extreme_count_limit) begin
                    extreme_cnt_next = '0;
                    right_err_next   = 1'b1;
                    left_err_next    = 1'b0;
                end
            end
        end else if (over_left) begin
            extreme_cnt_next = ext_inc;
            if (ext_inc > cfg.extreme_count_limit) begin
                extreme_cnt_next = '0;
                left_err_next    = 1'b1;
                right_err_next   = 1'b0;
            end
        end else if (in_band) begin
            extreme_cnt_next = '0;
            zero_cnt_next    = '0;
            left_err_next    = 1'b0;
            right_err_next   = 1'b0;
            settle_cnt_next  = settle_inc;
            if (settle_inc > (cfg.extreme_count_limit >> 1)) begin
                aligned_next    = 1'b1;
                settle_cnt_next = '0;
            end
        end
    end

    // Attitude from the freshly updated zones; reverse inverts the sign sense
    always_comb begin
        if (fwd) begin
            if (front_left_next)       att = rear_big ? ATT_LEFT_AWAY : ATT_LEFT_TOWARD;
            else if (front_right_next) att = rear_big ? ATT_RIGHT_TOWARD : ATT_RIGHT_AWAY;
            else                       att = ATT_INSIDE;
        end else begin
            if (back_left_next)        att = rear_big ? ATT_LEFT_TOWARD : ATT_LEFT_AWAY;
            else if (back_right_next)  att = rear_big ? ATT_RIGHT_AWAY : ATT_RIGHT_TOWARD;
            else                       att = ATT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_left_reg  <= 1'b1;
            front_right_reg <= 1'b1;
            back_left_reg   <= 1'b0;
            back_right_reg  <= 1'b0;
            offset_reg      <= '0;
            center_side_reg <= 1'b0;
            extreme_cnt_reg <= '0;
            zero_cnt_reg    <= '0;
            settle_cnt_reg  <= '0;
            aligned_reg     <= 1'b0;
            right_err_reg   <= 1'b0;
            left_err_reg    <= 1'b0;
        end else if (fire) begin
            front_left_reg  <= front_left_next;
            front_right_reg <= front_right_next;
            back_left_reg   <= back_left_next;
            back_right_reg  <= back_right_next;
            offset_reg      <= offset_next;
            center_side_reg <= center_side_next;
            extreme_cnt_reg <= extreme_cnt_next;
            zero_cnt_reg    <= zero_cnt_next;
            settle_cnt_reg  <= settle_cnt_next;
            aligned_reg     <= aligned_next;
            right_err_reg   <= right_err_next;
            left_err_reg    <= left_err_next;
        end
    end

    always_comb begin
        result.attitude_case     = att;
        result.sensor_difference = abs_diff(f, b);
        result.rear_larger       = rear_big;
        result.center_offset     = offset_next;
        result.center_right      = center_side_next;
        result.right_error       = right_err_next;
        result.left_error        = left_err_next;
        result.aligned_ok        = aligned_next;
    end

endmodule

`default_nettype wire

// File: hdl/lateral_deviation_classifier_top.sv
// Top level of the lateral deviation classifier: stream ports, input and result registers.
// Path: an accepted word is held in the input register, which feeds the core; the result
//   register captures the core's result, and tracking state updates at that same edge.
// Throughput: one word per cycle; while a result waits the input register takes one more
//   word, then s_tready drops until the sink takes the result.
// Reset: aresetn is synchronous, active low; it empties both registers and restores
//   the configuration and tracking state to their power-on values.
`default_nettype none

module lateral_deviation_classifier_top
    import ldc_pkg::*;
#(
    parameter int unsigned ZERO_READING_LIMIT = 20,
    parameter int unsigned HYST_MARGIN        = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration write port
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    // Input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // front_distance[11:0], back_distance[23:12], forward[24], backward[25], zero[31:26]
    input  wire logic [31:0]        s_tdata,
    // Result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // attitude_case[2:0], sensor_difference[14:3], rear_larger[15], center_offset[27:16],
    // center_right[28], right_error[29], left_error[30], aligned_ok[31]
    output logic [31:0]             m_tdata
);

    localparam int unsigned ITEM_W = $bits(ldc_item_t);

    ldc_cfg_t    cfg;
    ldc_item_t   item_reg;
    logic        in_valid_reg;
    ldc_result_t result;
    ldc_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    ldc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the held word into the result register whenever that register is free
    // or being emptied this cycle; the input register refills in the same cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload needs no reset: capture only on an accepted word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= ldc_item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    ldc_core #(
        .ZERO_READING_LIMIT (ZERO_READING_LIMIT),
        .HYST_MARGIN        (HYST_MARGIN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .fire    (fire),
        .result  (result)
    );

    // Result register: hold while the sink stalls, load when the core fires
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

`default_nettype wire

// File: hdl/ldc_checker.sv
// Port-level checker of the lateral deviation classifier, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ldc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result word changed")
    `ASSERT_IMPLIES(a_one_error, aclk, aresetn, m_tvalid, !(m_tdata[29] && m_tdata[30]), "left and right errors both set")
    `ASSERT_IMPLIES(a_case_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4, "attitude case out of range")
    `ASSERT_IMPLIES(a_sign_diff, aclk, aresetn, m_tvalid && m_tdata[15], m_tdata[14:3] != 12'd0, "rear larger with zero difference")

endmodule

bind lateral_deviation_classifier_top ldc_checker u_ldc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
